// ----- rtl/qgba_pkg.sv -----
// Package for the controlled quantum gate basis-term unit.
// Holds the field widths, register indexes, gate kinds and operation codes.
// No dependencies.
package qgba_pkg;

    localparam int WIRE_W    = 16;
    localparam int AMP_W     = 16;
    localparam int FRAC_W    = AMP_W - 1;
    localparam int WSEL_W    = 4;
    localparam int KIND_W    = 3;
    localparam int CIDX_W    = 3;
    localparam int CDAT_W    = 16;
    localparam int MOP_W     = AMP_W + 1;
    localparam int PROD_W    = AMP_W + MOP_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int TDATA_W   = WIRE_W + 2 * AMP_W;

    localparam logic signed [AMP_W-1:0] AMP_MAX = {1'b0, {(AMP_W-1){1'b1}}};
    localparam logic signed [AMP_W-1:0] AMP_MIN = {1'b1, {(AMP_W-1){1'b0}}};
    // 1/sqrt(2) in Q2.15
    localparam logic signed [MOP_W-1:0] ISQ2 = 17'sd23170;

    typedef enum logic [CIDX_W-1:0] {
        REG_GATE_KIND   = 3'd0,
        REG_CTRL_MASK   = 3'd1,
        REG_NEG_MASK    = 3'd2,
        REG_TGT0        = 3'd3,
        REG_TGT1        = 3'd4,
        REG_PHASE_COS   = 3'd5,
        REG_PHASE_SIN   = 3'd6,
        REG_SPARE       = 3'd7
    } t_reg_idx;

    typedef enum logic [KIND_W-1:0] {
        GATE_H      = 3'd0,
        GATE_X      = 3'd1,
        GATE_Y      = 3'd2,
        GATE_Z      = 3'd3,
        GATE_R      = 3'd4,
        GATE_SWAP   = 3'd5,
        GATE_RSV6   = 3'd6,
        GATE_RSV7   = 3'd7
    } t_gate;

    // How the amplitude of a result is formed in the second stage
    typedef enum logic [2:0] {
        OP_PASS = 3'd0,
        OP_NEG  = 3'd1,
        OP_YC1  = 3'd2,
        OP_YC0  = 3'd3,
        OP_MUL  = 3'd4
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               two;
        logic               hneg;
        logic [WIRE_W-1:0]  bits0;
        logic [WIRE_W-1:0]  bits1;
    } t_ctl;

    function automatic logic signed [AMP_W-1:0] neg_sat(input logic signed [AMP_W-1:0] v);
        logic signed [AMP_W-1:0] r;
        r = (v == AMP_MIN) ? AMP_MAX : -v;
        return r;
    endfunction

    // Round a Q4.30 sum to Q1.15, ties toward plus infinity, then saturate
    function automatic logic signed [AMP_W-1:0] rnd_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0]        t;
        logic signed [SUM_W-FRAC_W-1:0] q;
        logic signed [AMP_W-1:0]        r;
        t = s + (SUM_W'(1) <<< (FRAC_W - 1));
        q = t[SUM_W-1:FRAC_W];
        if (q > $signed((SUM_W-FRAC_W)'(AMP_MAX)))
            r = AMP_MAX;
        else if (q < $signed({{(SUM_W-FRAC_W-AMP_W){1'b1}}, AMP_MIN}))
            r = AMP_MIN;
        else
            r = q[AMP_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/quantum_gate_basis_apply.sv -----
// Top level of the controlled quantum gate basis-term unit.
// Depends on qgba_pkg for widths, register indexes, gate kinds and helpers.
//
// Usage:
//   Input words arrive on s_axis (basis bits, amplitude re, amplitude im).
//   Result words leave on m_axis; tlast marks the final result of a term.
//   Gate settings are written through i_cfg_we / i_cfg_idx / i_cfg_data
//   while no term is in flight; index 7 is ignored.
//   Pipeline: input register, product register, output buffer. An accepted
//   word passes through the input register and the product register into
//   the output buffer, which drives the port; each H term still ahead of it
//   in the buffer holds it back while that term's second word is sent.
//   Throughput: one term per cycle for X, Y, Z, R, swap and for terms whose
//   controls are not met, while m_axis_tready holds; an H term gives two
//   results and holds the single output channel, taking no new term, until both leave.
//   The output buffer holds one term's results (up to two words, the two
//   results of an H term).
//   Reset clears all valid flags and loads the gate registers with their
//   defaults (X gate, no controls, targets 0 and 1, phase cos AMP_MAX, sin 0).
//   When the receiver stalls, words stay in the buffer and the pipeline
//   fills; s_axis_tready drops once all three stages hold a term.
module quantum_gate_basis_apply
    import qgba_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // basis_bits [15:0], amp_re [31:16], amp_im [47:32]
    input  logic [TDATA_W-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // out_bits [15:0], out_re [31:16], out_im [47:32]
    output logic [TDATA_W-1:0]  m_axis_tdata,
    output logic                m_axis_tlast,
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_idx,
    input  logic [CDAT_W-1:0]   i_cfg_data
);

    // configuration
    t_gate                      r_kind;
    logic [WIRE_W-1:0]          r_cmask;
    logic [WIRE_W-1:0]          r_nmask;
    logic [WSEL_W-1:0]          r_tgt0;
    logic [WSEL_W-1:0]          r_tgt1;
    logic signed [AMP_W-1:0]    r_cos;
    logic signed [AMP_W-1:0]    r_sin;

    // stage 1: input register
    logic                       r1_v;
    logic [WIRE_W-1:0]          r1_bits;
    logic signed [AMP_W-1:0]    r1_are;
    logic signed [AMP_W-1:0]    r1_aim;

    // stage 2: products and decoded control
    logic                       r2_v;
    t_ctl                       r2_ctl;
    logic signed [AMP_W-1:0]    r2_are;
    logic signed [AMP_W-1:0]    r2_aim;
    logic signed [PROD_W-1:0]   r2_p0, r2_p1, r2_p2, r2_p3;

    // output buffer: slot 0 drives the port, slot 1 holds the second H word
    logic                       r_ov;
    logic                       r_o2v;
    logic [TDATA_W-1:0]         r_o0_data;
    logic                       r_o0_last;
    logic [TDATA_W-1:0]         r_o1_data;

    logic                       out_load_ok;
    logic                       s2_ready;
    logic                       in_take;

    t_ctl                       n_ctl;
    logic signed [MOP_W-1:0]    m0, m1, m2, m3;
    logic [WIRE_W-1:0]          oh0, oh1, sw;
    logic                       ctl_ok, col, b1;

    logic signed [AMP_W-1:0]    n_re, n_im, n_re1, n_im1;

    assign out_load_ok   = !r_ov || (m_axis_tready && !r_o2v);
    assign s2_ready      = !r2_v || out_load_ok;
    assign s_axis_tready = !r1_v || s2_ready;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_o0_data;
    assign m_axis_tlast  = r_o0_last;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= GATE_X;
            r_cmask <= '0;
            r_nmask <= '0;
            r_tgt0  <= WSEL_W'(0);
            r_tgt1  <= WSEL_W'(1);
            r_cos   <= AMP_MAX;
            r_sin   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_GATE_KIND: r_kind  <= t_gate'(i_cfg_data[KIND_W-1:0]);
                REG_CTRL_MASK: r_cmask <= i_cfg_data[WIRE_W-1:0];
                REG_NEG_MASK:  r_nmask <= i_cfg_data[WIRE_W-1:0];
                REG_TGT0:      r_tgt0  <= i_cfg_data[WSEL_W-1:0];
                REG_TGT1:      r_tgt1  <= i_cfg_data[WSEL_W-1:0];
                REG_PHASE_COS: r_cos   <= $signed(i_cfg_data[AMP_W-1:0]);
                REG_PHASE_SIN: r_sin   <= $signed(i_cfg_data[AMP_W-1:0]);
                default: ;
            endcase
        end
    end

    // stage 1 decode: controls, target column, rewritten bits, multiplier operands
    always_comb begin
        logic [WIRE_W-1:0] nm;
        logic [WIRE_W-1:0] pm;
        nm     = r_nmask & r_cmask;
        pm     = r_cmask & ~nm;
        ctl_ok = ((r1_bits & pm) == pm) && ((r1_bits & nm) == '0);
        oh0    = WIRE_W'(1) << r_tgt0;
        oh1    = WIRE_W'(1) << r_tgt1;
        col    = r1_bits[r_tgt0];
        b1     = r1_bits[r_tgt1];
        sw     = (r1_bits & ~oh0) | (b1 ? oh0 : '0);
        sw     = (sw & ~oh1) | (col ? oh1 : '0);

        n_ctl.op    = OP_PASS;
        n_ctl.two   = 1'b0;
        n_ctl.hneg  = col;
        n_ctl.bits0 = r1_bits;
        n_ctl.bits1 = r1_bits | oh0;
        m0 = '0;
        m1 = '0;
        m2 = '0;
        m3 = '0;

        if (ctl_ok) begin
            case (r_kind)
                GATE_H: begin
                    n_ctl.op    = OP_MUL;
                    n_ctl.two   = 1'b1;
                    n_ctl.bits0 = r1_bits & ~oh0;
                    m0 = ISQ2;
                    m3 = ISQ2;
                end
                GATE_X: begin
                    n_ctl.bits0 = r1_bits ^ oh0;
                end
                GATE_Y: begin
                    n_ctl.op    = col ? OP_YC1 : OP_YC0;
                    n_ctl.bits0 = r1_bits ^ oh0;
                end
                GATE_Z: begin
                    n_ctl.op = col ? OP_NEG : OP_PASS;
                end
                GATE_R: begin
                    n_ctl.op = col ? OP_MUL : OP_PASS;
                    m0 = MOP_W'(r_cos);
                    m1 = -MOP_W'(r_sin);
                    m2 = MOP_W'(r_sin);
                    m3 = MOP_W'(r_cos);
                end
                GATE_SWAP: begin
                    n_ctl.bits0 = sw;
                end
                default: ;
            endcase
        end
    end

    // stage 2 result forming: pass, negate or Y swap, or products with re = p0 + p1, im = p2 + p3
    always_comb begin
        logic signed [AMP_W-1:0] mre, mim;
        mre = rnd_sat(SUM_W'(r2_p0) + SUM_W'(r2_p1));
        mim = rnd_sat(SUM_W'(r2_p2) + SUM_W'(r2_p3));
        case (r2_ctl.op)
            OP_NEG: begin
                n_re = neg_sat(r2_are);
                n_im = neg_sat(r2_aim);
            end
            OP_YC1: begin
                n_re = r2_aim;
                n_im = neg_sat(r2_are);
            end
            OP_YC0: begin
                n_re = neg_sat(r2_aim);
                n_im = r2_are;
            end
            OP_MUL: begin
                n_re = mre;
                n_im = mim;
            end
            default: begin
                n_re = r2_are;
                n_im = r2_aim;
            end
        endcase
        n_re1 = r2_ctl.hneg ? neg_sat(mre) : mre;
        n_im1 = r2_ctl.hneg ? neg_sat(mim) : mim;
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r_ov  <= 1'b0;
            r_o2v <= 1'b0;
        end else begin
            if (s_axis_tready)
                r1_v <= s_axis_tvalid;
            if (s2_ready)
                r2_v <= r1_v;
            if (r2_v && out_load_ok) begin
                r_ov  <= 1'b1;
                r_o2v <= r2_ctl.two;
            end else if (r_ov && m_axis_tready) begin
                // advance the second word, or drain
                if (r_o2v)
                    r_o2v <= 1'b0;
                else
                    r_ov <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r1_bits <= s_axis_tdata[WIRE_W-1:0];
            r1_are  <= $signed(s_axis_tdata[WIRE_W +: AMP_W]);
            r1_aim  <= $signed(s_axis_tdata[WIRE_W+AMP_W +: AMP_W]);
        end
        if (s2_ready) begin
            r2_ctl <= n_ctl;
            r2_are <= r1_are;
            r2_aim <= r1_aim;
            r2_p0  <= PROD_W'(r1_are) * PROD_W'(m0);
            r2_p1  <= PROD_W'(r1_aim) * PROD_W'(m1);
            r2_p2  <= PROD_W'(r1_are) * PROD_W'(m2);
            r2_p3  <= PROD_W'(r1_aim) * PROD_W'(m3);
        end
        if (r2_v && out_load_ok) begin
            r_o0_data <= {n_im, n_re, r2_ctl.bits0};
            r_o0_last <= !r2_ctl.two;
            r_o1_data <= {n_im1, n_re1, r2_ctl.bits1};
        end else if (r_ov && m_axis_tready && r_o2v) begin
            r_o0_data <= r_o1_data;
            r_o0_last <= 1'b1;
        end
    end

endmodule
